>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is low.
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/v4al_pkg.sv
// Shared types for the four-component vector arithmetic unit.
// No dependencies; used by the vec4_arith_length_normalize top level.
package v4al_pkg;

  // Operation codes carried on in_mode.
  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_MUL   = 4'd2,
    MODE_DIV   = 4'd3,
    MODE_SCALE = 4'd4,
    MODE_DIVS  = 4'd5,
    MODE_DOT   = 4'd6,
    MODE_LENSQ = 4'd7,
    MODE_LEN   = 4'd8,
    MODE_DIST  = 4'd9,
    MODE_NORM  = 4'd10,
    MODE_LIMIT = 4'd11,
    MODE_NEG   = 4'd12,
    MODE_TRUNC = 4'd13
  } mode_t;

endpackage

>>> design/vec4_arith_length_normalize.sv
// Four-component fixed-point vector unit: add, multiply, divide, dot, length, normalize.
// Depends on v4al_pkg for the operation codes.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+---------------------------------------------
//   input     | start && !busy          | in_mode, in_a_*, in_b_*, in_scalar_in
//   result    | out_valid (one cycle)   | out_r_*, out_scalar_out, out_error_flag
//
// One item can be taken on every clock; busy is high only in reset and in the cycle after it.
// Each result passes the input registers, the stage 1 and stage 2 registers, the root
// entry register, the bit-per-stage square root (COMP_WIDTH+2 stages), the divider setup
// register, the bit-per-stage divider (COMP_WIDTH stages) and the output register.
// Reset is synchronous, sets busy and clears only the valid bits along the pipeline.
// The receiver cannot stall, so the pipeline never holds; results leave in order.
module vec4_arith_length_normalize #(
  parameter int FRAC_BITS  = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [3:0]                   in_mode,
  input  logic signed [COMP_WIDTH-1:0] in_a_x,
  input  logic signed [COMP_WIDTH-1:0] in_a_y,
  input  logic signed [COMP_WIDTH-1:0] in_a_z,
  input  logic signed [COMP_WIDTH-1:0] in_a_w,
  input  logic signed [COMP_WIDTH-1:0] in_b_x,
  input  logic signed [COMP_WIDTH-1:0] in_b_y,
  input  logic signed [COMP_WIDTH-1:0] in_b_z,
  input  logic signed [COMP_WIDTH-1:0] in_b_w,
  input  logic signed [COMP_WIDTH-1:0] in_scalar_in,
  output logic                         out_valid,
  output logic signed [COMP_WIDTH-1:0] out_r_x,
  output logic signed [COMP_WIDTH-1:0] out_r_y,
  output logic signed [COMP_WIDTH-1:0] out_r_z,
  output logic signed [COMP_WIDTH-1:0] out_r_w,
  output logic signed [COMP_WIDTH-1:0] out_scalar_out,
  output logic                         out_error_flag
);
  import v4al_pkg::*;

  localparam int W   = COMP_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W + 1;             // one product of magnitudes
  localparam int SQW = 2 * W + 3;             // sum of four squares
  localparam int SW  = 2 * W + 4;             // signed sum of four products
  localparam int MW  = 2 * W + 4;             // widest magnitude fed to saturation
  localparam int RW  = W + 2;                 // square root
  localparam int CW  = 2 * W + 5;             // square root trial value
  localparam int DW  = W + 1;                 // divisor
  localparam int NW  = W + ((F > W) ? F : W); // dividend
  localparam int XW  = NW + 1;                // divider remainder

  localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] TMASK = {W{1'b1}} << F;

  // Item fields that travel unchanged through the root and divider stages.
  typedef struct packed {
    mode_t              mode;
    logic [3:0][W-1:0]  r;     // result when no division is used
    logic [3:0][NW-1:0] num;   // dividend per lane
    logic [3:0][W-1:0]  dv;    // divisor per lane for div and divscalar
    logic [3:0]         qn;    // quotient sign per lane
    logic [3:0]         zr;    // lane forced to zero
    logic [W-1:0]       so;    // scalar result
    logic               err;
    logic               take;  // limit rescales the vector
  } item_t;

  // Saturate a sign and magnitude to W bits.
  function automatic logic [W-1:0] sat_f(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] lim;
    logic [W-1:0]  res;
    lim = MW'(VMAX);
    if (neg) begin
      if (mag > lim + MW'(1)) res = VMIN;
      else res = W'(~mag + MW'(1));
    end else begin
      if (mag > lim) res = VMAX;
      else res = mag[W-1:0];
    end
    return res;
  endfunction

  // Clamp a W+1 bit two's complement value to W bits.
  function automatic logic [W-1:0] clamp_f(input logic [W:0] v);
    logic [W-1:0] res;
    if (v[W] != v[W-1]) res = v[W] ? VMIN : VMAX;
    else res = v[W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input registers.
  logic              acc;
  logic              busy_r;
  logic              v0_r;
  mode_t             mode0_r;
  logic [3:0][W-1:0] a_in, b_in;
  logic [3:0][W-1:0] a0_r, b0_r;
  logic [W-1:0]      s0_r;

  assign acc  = start && !busy_r;
  assign busy = busy_r;
  assign a_in = {in_a_w, in_a_z, in_a_y, in_a_x};
  assign b_in = {in_b_w, in_b_z, in_b_y, in_b_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      v0_r   <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      v0_r   <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mode0_r <= mode_t'(in_mode);
      a0_r    <= a_in;
      b0_r    <= b_in;
      s0_r    <= in_scalar_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: magnitudes, multiplier operands, products and the simple operations.
  logic [3:0]          aneg, bneg;
  logic [3:0][W-1:0]   amag, bmag;
  logic [3:0][W:0]     dif, dmag, opx, opy;
  logic                sneg;
  logic [W-1:0]        smag, mpos;
  logic [2*W+1:0]      prod [4];
  logic [2*W-1:0]      lprod [4];
  logic [2*W-1:0]      mm_nxt;
  logic [3:0][PW-1:0]  p1_nxt;
  logic [3:0][W-1:0]   r1_nxt, dv1_nxt;
  logic [3:0]          ng1_nxt, qn1_nxt, zr1_nxt;
  logic                err1_nxt;
  logic [W-1:0]        tm;

  always_comb begin
    sneg = s0_r[W-1];
    smag = sneg ? (~s0_r + W'(1)) : s0_r;
    mpos = sneg ? '0 : s0_r;
    for (int i = 0; i < 4; i++) begin
      aneg[i] = a0_r[i][W-1];
      bneg[i] = b0_r[i][W-1];
      amag[i] = aneg[i] ? (~a0_r[i] + W'(1)) : a0_r[i];
      bmag[i] = bneg[i] ? (~b0_r[i] + W'(1)) : b0_r[i];
      dif[i]  = {a0_r[i][W-1], a0_r[i]} - {b0_r[i][W-1], b0_r[i]};
      dmag[i] = dif[i][W] ? (~dif[i] + (W+1)'(1)) : dif[i];
    end
  end

  // Operand selection for the four lane multipliers.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (mode0_r)
        MODE_MUL, MODE_DOT: begin
          opx[i]     = (W+1)'(amag[i]);
          opy[i]     = (W+1)'(bmag[i]);
          ng1_nxt[i] = aneg[i] ^ bneg[i];
        end
        MODE_SCALE: begin
          opx[i]     = (W+1)'(amag[i]);
          opy[i]     = (W+1)'(smag);
          ng1_nxt[i] = aneg[i] ^ sneg;
        end
        MODE_DIST: begin
          opx[i]     = dmag[i];
          opy[i]     = dmag[i];
          ng1_nxt[i] = 1'b0;
        end
        default: begin
          opx[i]     = (W+1)'(amag[i]);
          opy[i]     = (W+1)'(amag[i]);
          ng1_nxt[i] = 1'b0;
        end
      endcase
      prod[i]   = opx[i] * opy[i];
      lprod[i]  = amag[i] * mpos;
      p1_nxt[i] = prod[i][PW-1:0];
    end
    mm_nxt = mpos * mpos;
  end

  // Results that need no product, and the divider lane setup.
  always_comb begin
    err1_nxt = 1'b0;
    tm       = '0;
    for (int i = 0; i < 4; i++) begin
      r1_nxt[i]  = '0;
      dv1_nxt[i] = smag;
      qn1_nxt[i] = aneg[i];
      zr1_nxt[i] = 1'b0;
      case (mode0_r)
        MODE_ADD: r1_nxt[i] = clamp_f({a0_r[i][W-1], a0_r[i]} + {b0_r[i][W-1], b0_r[i]});
        MODE_SUB: r1_nxt[i] = clamp_f(dif[i]);
        MODE_NEG: r1_nxt[i] = clamp_f(~{a0_r[i][W-1], a0_r[i]} + (W+1)'(1));
        MODE_TRUNC: begin
          tm        = amag[i] & TMASK;
          r1_nxt[i] = aneg[i] ? (~tm + W'(1)) : tm;
        end
        MODE_LIMIT: r1_nxt[i] = a0_r[i];
        MODE_DIV: begin
          dv1_nxt[i] = bmag[i];
          qn1_nxt[i] = aneg[i] ^ bneg[i];
          zr1_nxt[i] = (b0_r[i] == '0);
          if (b0_r[i] == '0) err1_nxt = 1'b1;
        end
        MODE_DIVS: begin
          qn1_nxt[i] = aneg[i] ^ sneg;
          zr1_nxt[i] = (s0_r == '0);
          if (s0_r == '0) err1_nxt = 1'b1;
        end
        default: r1_nxt[i] = '0;
      endcase
    end
  end

  logic                 v1_r;
  mode_t                mode1_r;
  logic [3:0][PW-1:0]   p1_r;
  logic [3:0][2*W-1:0]  lp1_r;
  logic [2*W-1:0]       mm1_r;
  logic [3:0][W-1:0]    r1_r, dv1_r, ma1_r;
  logic [3:0]           ng1_r, qn1_r, zr1_r;
  logic                 err1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    mode1_r <= mode0_r;
    p1_r    <= p1_nxt;
    mm1_r   <= mm_nxt;
    r1_r    <= r1_nxt;
    dv1_r   <= dv1_nxt;
    ma1_r   <= amag;
    ng1_r   <= ng1_nxt;
    qn1_r   <= qn1_nxt;
    zr1_r   <= zr1_nxt;
    err1_r  <= err1_nxt;
    for (int i = 0; i < 4; i++) lp1_r[i] <= lprod[i];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: signed sum of products, product results, dividends.
  logic [3:0][SW-1:0] term;
  logic [SW-1:0]      sum2_nxt;
  logic [3:0][W-1:0]  r2_nxt;
  logic [3:0][NW-1:0] num2_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      term[i] = ng1_r[i] ? (~SW'(p1_r[i]) + SW'(1)) : SW'(p1_r[i]);
      if (mode1_r == MODE_MUL || mode1_r == MODE_SCALE) begin
        r2_nxt[i] = sat_f(ng1_r[i], MW'(p1_r[i] >> F));
      end else begin
        r2_nxt[i] = r1_r[i];
      end
      if (mode1_r == MODE_LIMIT) num2_nxt[i] = NW'(lp1_r[i]);
      else num2_nxt[i] = NW'(ma1_r[i]) << F;
    end
    sum2_nxt = term[0] + term[1] + term[2] + term[3];
  end

  logic               v2_r;
  mode_t              mode2_r;
  logic [SW-1:0]      sum2_r;
  logic [2*W-1:0]     mm2_r;
  logic [3:0][W-1:0]  r2_r, dv2_r;
  logic [3:0][NW-1:0] num2_r;
  logic [3:0]         qn2_r, zr2_r;
  logic               err2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    mode2_r <= mode1_r;
    sum2_r  <= sum2_nxt;
    mm2_r   <= mm1_r;
    r2_r    <= r2_nxt;
    dv2_r   <= dv1_r;
    num2_r  <= num2_nxt;
    qn2_r   <= qn1_r;
    zr2_r   <= zr1_r;
    err2_r  <= err1_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot and squared length results, limit test, root pipeline entry.
  logic [SW-1:0] smag3;
  item_t         it3_nxt;

  always_comb begin
    smag3           = sum2_r[SW-1] ? (~sum2_r + SW'(1)) : sum2_r;
    it3_nxt.mode    = mode2_r;
    it3_nxt.r       = r2_r;
    it3_nxt.num     = num2_r;
    it3_nxt.dv      = dv2_r;
    it3_nxt.qn      = qn2_r;
    it3_nxt.zr      = zr2_r;
    it3_nxt.err     = err2_r;
    it3_nxt.take    = (mode2_r == MODE_LIMIT) && (sum2_r[SQW-1:0] > SQW'(mm2_r));
    case (mode2_r)
      MODE_DOT:   it3_nxt.so = sat_f(sum2_r[SW-1], MW'(smag3 >> F));
      MODE_LENSQ: it3_nxt.so = sat_f(1'b0, MW'(sum2_r >> F));
      default:    it3_nxt.so = '0;
    endcase
  end

  // Square root, one result bit per stage, most significant first.
  logic           sq_v_r    [RW+1];
  item_t          sq_item_r [RW+1];
  logic [SQW-1:0] sq_rem_r  [RW+1];
  logic [RW-1:0]  sq_root_r [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else sq_v_r[0] <= v2_r;
  end

  always_ff @(posedge clk) begin
    sq_item_r[0] <= it3_nxt;
    sq_rem_r[0]  <= sum2_r[SQW-1:0];
    sq_root_r[0] <= '0;
  end

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    localparam int K = RW - j;
    logic [CW-1:0]  trial;
    logic [SQW-1:0] rem_nxt;
    logic [RW-1:0]  root_nxt;

    // Accept bit K when (root + 2^K)^2 still fits under the radicand.
    always_comb begin
      trial = (CW'(sq_root_r[j-1]) << (K + 1)) | (CW'(1) << (2 * K));
      if (CW'(sq_rem_r[j-1]) >= trial) begin
        rem_nxt  = sq_rem_r[j-1] - trial[SQW-1:0];
        root_nxt = sq_root_r[j-1] | (RW'(1) << K);
      end else begin
        rem_nxt  = sq_rem_r[j-1];
        root_nxt = sq_root_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j] <= 1'b0;
      else sq_v_r[j] <= sq_v_r[j-1];
    end

    always_ff @(posedge clk) begin
      sq_item_r[j] <= sq_item_r[j-1];
      sq_rem_r[j]  <= rem_nxt;
      sq_root_r[j] <= root_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider setup: pick divisors, flag quotients that overflow W bits.
  item_t              ds_item_nxt;
  logic [3:0][DW-1:0] ds_d_nxt;
  logic [3:0]         ds_ovf_nxt;
  logic [RW-1:0]      root;
  logic               use_len;

  always_comb begin
    root        = sq_root_r[RW];
    ds_item_nxt = sq_item_r[RW];
    use_len     = (ds_item_nxt.mode == MODE_NORM) || (ds_item_nxt.mode == MODE_LIMIT);
    if (ds_item_nxt.mode == MODE_LEN || ds_item_nxt.mode == MODE_DIST) begin
      ds_item_nxt.so = sat_f(1'b0, MW'(root));
    end
    if (ds_item_nxt.mode == MODE_NORM && root == '0) begin
      ds_item_nxt.err = 1'b1;
      ds_item_nxt.zr  = '1;
    end
    for (int i = 0; i < 4; i++) begin
      ds_d_nxt[i]   = use_len ? root[DW-1:0] : DW'(ds_item_nxt.dv[i]);
      ds_ovf_nxt[i] = XW'(ds_item_nxt.num[i]) >= (XW'(ds_d_nxt[i]) << W);
    end
  end

  logic               dv_v_r    [W+1];
  item_t              dv_item_r [W+1];
  logic [3:0][XW-1:0] dv_rem_r  [W+1];
  logic [3:0][W-1:0]  dv_q_r    [W+1];
  logic [3:0][DW-1:0] dv_d_r    [W+1];
  logic [3:0]         dv_ovf_r  [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else dv_v_r[0] <= sq_v_r[RW];
  end

  always_ff @(posedge clk) begin
    dv_item_r[0] <= ds_item_nxt;
    dv_d_r[0]    <= ds_d_nxt;
    dv_ovf_r[0]  <= ds_ovf_nxt;
    dv_q_r[0]    <= '0;
    for (int i = 0; i < 4; i++) dv_rem_r[0][i] <= XW'(ds_item_nxt.num[i]);
  end

  // Restoring divider, four lanes, one quotient bit per stage.
  for (genvar j = 1; j <= W; j++) begin : g_div
    localparam int K = W - j;
    logic [3:0][XW-1:0] rem_nxt;
    logic [3:0][W-1:0]  q_nxt;
    logic [3:0][XW-1:0] shd;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        shd[i] = XW'(dv_d_r[j-1][i]) << K;
        if (dv_rem_r[j-1][i] >= shd[i]) begin
          rem_nxt[i] = dv_rem_r[j-1][i] - shd[i];
          q_nxt[i]   = dv_q_r[j-1][i] | (W'(1) << K);
        end else begin
          rem_nxt[i] = dv_rem_r[j-1][i];
          q_nxt[i]   = dv_q_r[j-1][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else dv_v_r[j] <= dv_v_r[j-1];
    end

    always_ff @(posedge clk) begin
      dv_item_r[j] <= dv_item_r[j-1];
      dv_d_r[j]    <= dv_d_r[j-1];
      dv_ovf_r[j]  <= dv_ovf_r[j-1];
      dv_rem_r[j]  <= rem_nxt;
      dv_q_r[j]    <= q_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: saturate quotients and choose each lane's result.
  item_t             fin;
  logic [3:0][W-1:0] satq, rout_nxt;
  logic              use_div;

  always_comb begin
    fin = dv_item_r[W];
    case (fin.mode)
      MODE_DIV, MODE_DIVS, MODE_NORM: use_div = 1'b1;
      MODE_LIMIT:                     use_div = fin.take;
      default:                        use_div = 1'b0;
    endcase
    for (int i = 0; i < 4; i++) begin
      if (dv_ovf_r[W][i]) satq[i] = fin.qn[i] ? VMIN : VMAX;
      else satq[i] = sat_f(fin.qn[i], MW'(dv_q_r[W][i]));
      if (use_div) rout_nxt[i] = fin.zr[i] ? '0 : satq[i];
      else rout_nxt[i] = fin.r[i];
    end
  end

  logic              out_valid_r;
  logic [3:0][W-1:0] out_r_r;
  logic [W-1:0]      out_so_r;
  logic              out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= dv_v_r[W];
  end

  always_ff @(posedge clk) begin
    out_r_r   <= rout_nxt;
    out_so_r  <= fin.so;
    out_err_r <= fin.err;
  end

  assign out_valid      = out_valid_r;
  assign out_r_x        = out_r_r[0];
  assign out_r_y        = out_r_r[1];
  assign out_r_z        = out_r_r[2];
  assign out_r_w        = out_r_r[3];
  assign out_scalar_out = out_so_r;
  assign out_error_flag = out_err_r;

endmodule

>>> design/v4al_check.sv
// Port-level checker for vec4_arith_length_normalize, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module v4al_check #(
  parameter int COMP_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [COMP_WIDTH-1:0] out_r_x,
  input logic [COMP_WIDTH-1:0] out_r_y,
  input logic [COMP_WIDTH-1:0] out_r_z,
  input logic [COMP_WIDTH-1:0] out_r_w,
  input logic [COMP_WIDTH-1:0] out_scalar_out,
  input logic                  out_error_flag
);
  // Edges from an input transfer to the edge that takes its result.
  localparam int LAT = 2 * COMP_WIDTH + 8;

  logic acc;
  logic vec_zero;

  assign acc      = start && !busy;
  assign vec_zero = (out_r_x == '0) && (out_r_y == '0) && (out_r_z == '0) &&
                    (out_r_w == '0);

  // Every result transfer comes from an input transfer a fixed time earlier.
  `ASSERT_CHK(a_latency, clk, rst_n, out_valid |-> $past(acc, LAT), "result without input")

  // Errors only arise in vector modes, whose scalar result is zero.
  `ASSERT_CHK(a_err_scalar, clk, rst_n, (out_valid && out_error_flag) |-> (out_scalar_out == '0), "error with scalar result")

  // A nonzero scalar result comes with a zero vector.
  `ASSERT_CHK(a_scalar_vec, clk, rst_n, (out_valid && (out_scalar_out != '0)) |-> vec_zero, "scalar and vector both set")

  // Reset drops the result strobe.
  `ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

bind vec4_arith_length_normalize v4al_check #(
  .COMP_WIDTH(COMP_WIDTH)
) u_v4al_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_r_x       (out_r_x),
  .out_r_y       (out_r_y),
  .out_r_z       (out_r_z),
  .out_r_w       (out_r_w),
  .out_scalar_out(out_scalar_out),
  .out_error_flag(out_error_flag)
);

>>> tb/sv/tb_vec4_arith_length_normalize.sv
// Self-checking testbench for the four-component fixed-point vector unit.
// It drives directed and random transfers and compares every result with its own prediction.
// It depends on v4al_pkg and the vec4_arith_length_normalize top level.
`timescale 1ns / 100ps

module tb_vec4_arith_length_normalize;
  import v4al_pkg::*;

  localparam int FB = 16;
  localparam int CW = 32;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [3:0] MODE_SPARE_LO = 4'd14;
  localparam logic [3:0] MODE_SPARE_HI = 4'd15;
  localparam logic signed [CW-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] Q_MIN = 32'sh80000000;
  localparam logic signed [CW-1:0] Q_ONE = 32'sh00010000;

  typedef struct {
    logic [3:0]             mode;
    logic signed [CW-1:0]   a[4];
    logic signed [CW-1:0]   b[4];
    logic signed [CW-1:0]   s;
  } vec_op_t;

  typedef struct {
    logic signed [CW-1:0]   r[4];
    logic signed [CW-1:0]   so;
    logic                   err;
  } vec_res_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [3:0] in_mode;
  logic signed [CW-1:0] in_a_x, in_a_y, in_a_z, in_a_w;
  logic signed [CW-1:0] in_b_x, in_b_y, in_b_z, in_b_w;
  logic signed [CW-1:0] in_scalar_in;
  logic out_valid;
  logic signed [CW-1:0] out_r_x, out_r_y, out_r_z, out_r_w, out_scalar_out;
  logic out_error_flag;

  vec_res_t pending_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;

  vec4_arith_length_normalize uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .in_scalar_in(in_scalar_in),
    .out_valid(out_valid),
    .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z), .out_r_w(out_r_w),
    .out_scalar_out(out_scalar_out), .out_error_flag(out_error_flag)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Fixed-point helpers at full precision.
  function automatic bit [127:0] mag_of(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [CW-1:0] saturate(bit neg, bit [127:0] m);
    if (neg) begin
      if (m > 128'h80000000) return Q_MIN;
      return 32'(-m);
    end
    if (m > 128'h7fffffff) return Q_MAX;
    return m[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] fx_mul(longint x, longint y);
    return saturate((x < 0) != (y < 0), (mag_of(x) * mag_of(y)) >> FB);
  endfunction

  function automatic logic [CW-1:0] fx_div(longint x, longint y);
    return saturate((x < 0) != (y < 0), (mag_of(x) << FB) / mag_of(y));
  endfunction

  function automatic bit [127:0] sum_squares(longint v[4]);
    bit [127:0] acc;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += mag_of(v[i]) * mag_of(v[i]);
    return acc;
  endfunction

  // Floor of the square root, one bit per step from the top.
  function automatic bit [127:0] int_sqrt(bit [127:0] sq);
    bit [127:0] root;
    bit [127:0] trial;
    root = 0;
    for (int k = 63; k >= 0; k--) begin
      trial = root | (128'd1 << k);
      if (trial * trial <= sq) root = trial;
    end
    return root;
  endfunction

  // Expected outputs for one operation.
  function automatic vec_res_t vec_unit_result(vec_op_t op);
    vec_res_t res;
    longint av[4], bv[4], dv[4];
    longint sv;
    bit [127:0] pos, negs, t, sq, len, lim;
    res.so = '0;
    res.err = 1'b0;
    for (int i = 0; i < 4; i++) begin
      res.r[i] = '0;
      av[i] = op.a[i];
      bv[i] = op.b[i];
      dv[i] = av[i] - bv[i];
    end
    sv = op.s;
    case (op.mode)
      MODE_ADD: for (int i = 0; i < 4; i++)
        res.r[i] = saturate(av[i] + bv[i] < 0, mag_of(av[i] + bv[i]));
      MODE_SUB: for (int i = 0; i < 4; i++)
        res.r[i] = saturate(dv[i] < 0, mag_of(dv[i]));
      MODE_MUL: for (int i = 0; i < 4; i++) res.r[i] = fx_mul(av[i], bv[i]);
      MODE_DIV: for (int i = 0; i < 4; i++) begin
        if (bv[i] == 0) res.err = 1'b1;
        else res.r[i] = fx_div(av[i], bv[i]);
      end
      MODE_SCALE: for (int i = 0; i < 4; i++) res.r[i] = fx_mul(av[i], sv);
      MODE_DIVS: begin
        if (sv == 0) res.err = 1'b1;
        else for (int i = 0; i < 4; i++) res.r[i] = fx_div(av[i], sv);
      end
      MODE_DOT: begin
        pos = 0;
        negs = 0;
        for (int i = 0; i < 4; i++) begin
          t = mag_of(av[i]) * mag_of(bv[i]);
          if ((av[i] < 0) != (bv[i] < 0)) negs += t;
          else pos += t;
        end
        if (pos >= negs) res.so = saturate(1'b0, (pos - negs) >> FB);
        else res.so = saturate(1'b1, (negs - pos) >> FB);
      end
      MODE_LENSQ: res.so = saturate(1'b0, sum_squares(av) >> FB);
      MODE_LEN: res.so = saturate(1'b0, int_sqrt(sum_squares(av)));
      MODE_DIST: res.so = saturate(1'b0, int_sqrt(sum_squares(dv)));
      MODE_NORM: begin
        len = int_sqrt(sum_squares(av));
        if (len == 0) res.err = 1'b1;
        else for (int i = 0; i < 4; i++)
          res.r[i] = saturate(av[i] < 0, (mag_of(av[i]) << FB) / len);
      end
      MODE_LIMIT: begin
        // A negative limit counts as zero; only longer vectors are shortened.
        sq = sum_squares(av);
        lim = (sv < 0) ? 128'd0 : 128'(sv);
        if (sq > lim * lim) begin
          len = int_sqrt(sq);
          for (int i = 0; i < 4; i++)
            res.r[i] = saturate(av[i] < 0, (mag_of(av[i]) * lim) / len);
        end else begin
          for (int i = 0; i < 4; i++) res.r[i] = op.a[i];
        end
      end
      MODE_NEG: for (int i = 0; i < 4; i++) res.r[i] = saturate(av[i] > 0, mag_of(av[i]));
      MODE_TRUNC: for (int i = 0; i < 4; i++)
        res.r[i] = saturate(av[i] < 0, (mag_of(av[i]) >> FB) << FB);
      default: ;
    endcase
    return res;
  endfunction

  // One transfer: present the operation, wait for it to be taken, record the prediction.
  task automatic send_op(vec_op_t op);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= op.mode;
    in_a_x <= op.a[0]; in_a_y <= op.a[1]; in_a_z <= op.a[2]; in_a_w <= op.a[3];
    in_b_x <= op.b[0]; in_b_y <= op.b[1]; in_b_z <= op.b[2]; in_b_w <= op.b[3];
    in_scalar_in <= op.s;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(vec_unit_result(op));
  endtask

  function automatic vec_op_t make_op(logic [3:0] mode, logic signed [CW-1:0] ax,
                                      logic signed [CW-1:0] ay, logic signed [CW-1:0] az,
                                      logic signed [CW-1:0] aw, logic signed [CW-1:0] bx,
                                      logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
                                      logic signed [CW-1:0] bw, logic signed [CW-1:0] s);
    vec_op_t op;
    op.mode = mode;
    op.a[0] = ax; op.a[1] = ay; op.a[2] = az; op.a[3] = aw;
    op.b[0] = bx; op.b[1] = by; op.b[2] = bz; op.b[3] = bw;
    op.s = s;
    return op;
  endfunction

  // Random component: full range, small values, zero and the extremes.
  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2, 3: return $signed($urandom_range(0, 8 << FB)) - (4 << FB);
      4: return '0;
      5: return Q_MAX;
      6: return Q_MIN;
      default: return $signed($urandom_range(0, 510)) - 255;
    endcase
  endfunction

  task automatic test_componentwise();
    send_op(make_op(MODE_ADD, Q_MAX, Q_MIN, Q_ONE, -Q_ONE, Q_MAX, Q_MIN, Q_ONE, 5, 0));
    send_op(make_op(MODE_SUB, Q_MIN, Q_MAX, 0, 3, Q_MAX, Q_MIN, 0, -7, 0));
    send_op(make_op(MODE_MUL, Q_MAX, Q_MIN, Q_MIN, -Q_ONE, Q_MAX, Q_MAX, Q_MIN, 3, 0));
    send_op(make_op(MODE_DIV, Q_ONE, Q_MAX, -5, 7, 0, 1, 3 << FB, -Q_ONE, 0));
    send_op(make_op(MODE_DIV, Q_MIN, 9 << FB, 1, -1, -Q_ONE, 2 << FB, Q_MAX, Q_MIN, 0));
    send_op(make_op(MODE_SCALE, Q_MAX, -3 << FB, 12345, Q_MIN, 0, 0, 0, 0, -2 << FB));
    send_op(make_op(MODE_DIVS, Q_ONE, 2, 3, 4, 0, 0, 0, 0, 0));
    send_op(make_op(MODE_DIVS, Q_MAX, Q_MIN, 7 << FB, -1, 0, 0, 0, 0, 3));
    send_op(make_op(MODE_NEG, Q_MIN, Q_MAX, 0, -1, 0, 0, 0, 0, 0));
    send_op(make_op(MODE_TRUNC, -(3 << FB) - 1, (5 << FB) + 7, Q_MIN, Q_MAX, 0, 0, 0, 0, 0));
  endtask

  task automatic test_reductions();
    send_op(make_op(MODE_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0));
    send_op(make_op(MODE_DOT, Q_MIN, 2 << FB, -1, 5, Q_MAX, 3 << FB, 9, -4, 0));
    send_op(make_op(MODE_LENSQ, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0));
    send_op(make_op(MODE_LEN, 3 << FB, 4 << FB, 0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(MODE_LEN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0));
    send_op(make_op(MODE_DIST, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0));
  endtask

  task automatic test_normalize_limit();
    send_op(make_op(MODE_NORM, 0, 0, 0, 0, 1, 2, 3, 4, 5));
    send_op(make_op(MODE_NORM, 3 << FB, -4 << FB, 1, 0, 0, 0, 0, 0, 0));
    send_op(make_op(MODE_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_op(make_op(MODE_LIMIT, 30 << FB, 40 << FB, 0, 0, 0, 0, 0, 0, 5 << FB));
    send_op(make_op(MODE_LIMIT, Q_ONE, 2, 3, 4, 0, 0, 0, 0, Q_MAX));
    send_op(make_op(MODE_LIMIT, Q_ONE, -Q_ONE, 5, 0, 0, 0, 0, 0, -Q_ONE));
    send_op(make_op(MODE_LIMIT, 0, 0, 0, 0, 0, 0, 0, 0, Q_MIN));
    send_op(make_op(MODE_SPARE_LO, Q_MAX, 1, 2, 3, 4, 5, 6, 7, 8));
    send_op(make_op(MODE_SPARE_HI, Q_MIN, -1, -2, -3, -4, -5, -6, -7, -8));
  endtask

  task automatic test_random_ops(int count);
    vec_op_t op;
    for (int n = 0; n < count; n++) begin
      op.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(14, 15))
                                             : 4'($urandom_range(0, 13));
      for (int i = 0; i < 4; i++) begin
        op.a[i] = rand_comp();
        op.b[i] = rand_comp();
      end
      op.s = rand_comp();
      send_op(op);
    end
  endtask

  // Result checker and watchdog, both sampled away from the driving edge.
  always @(negedge clk) begin
    vec_res_t exp_res;
    logic signed [CW-1:0] got[4];
    string names[4];
    names = '{"r_x", "r_y", "r_z", "r_w"};
    got = '{out_r_x, out_r_y, out_r_z, out_r_w};
    if (rst_n && (out_valid || (start && !busy))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation waiting");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        for (int i = 0; i < 4; i++)
          if (got[i] !== exp_res.r[i]) begin
            $error("%s: expected %h, actual %h", names[i], exp_res.r[i], got[i]);
            fail_count++;
          end
        if (out_scalar_out !== exp_res.so) begin
          $error("scalar_out: expected %h, actual %h", exp_res.so, out_scalar_out);
          fail_count++;
        end
        if (out_error_flag !== exp_res.err) begin
          $error("error_flag: expected %b, actual %b", exp_res.err, out_error_flag);
          fail_count++;
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= '0;
    in_a_x <= '0; in_a_y <= '0; in_a_z <= '0; in_a_w <= '0;
    in_b_x <= '0; in_b_y <= '0; in_b_z <= '0; in_b_w <= '0;
    in_scalar_in <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 0;
    test_componentwise();
    sender_idle_pct = 71;
    test_reductions();
    sender_idle_pct = 34;
    test_normalize_limit();
    sender_idle_pct = 0;
    test_random_ops(150);
    sender_idle_pct = 71;
    test_random_ops(150);
    sender_idle_pct = 34;
    test_random_ops(150);
    start <= 1'b0;

    // Drain the pipeline, then leave room for any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/v4al_pkg.sv
design/vec4_arith_length_normalize.sv
design/v4al_check.sv
tb/sv/tb_vec4_arith_length_normalize.sv
